@@ rtl/lpr_pkg.sv @@
// Package for the line/rectangle/triangle outline rasterizer.
// Coordinate widths, command codes, edge numbering and the per-edge stepper state.
// No dependencies.
`default_nettype none

package lpr_pkg;

    localparam int COORD_BITS = 11;
    localparam int DELTA_BITS = COORD_BITS + 1;  // absolute difference of two coordinates
    localparam int ERR_BITS   = COORD_BITS + 2;  // Bresenham error term
    localparam int WIDE_BITS  = COORD_BITS + 3;  // twice the error term, with headroom

    localparam int S_TDATA_BITS = ((6 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CMD_LINE = 2'd0,
        CMD_RECT = 2'd1,
        CMD_TRI  = 2'd2,
        CMD_STEP = 2'd3
    } t_cmd;

    // Edge order: rectangle top, bottom, left, right; triangle 1-2, 2-3, 3-1
    localparam logic [1:0] EDGE_FIRST  = 2'd0;
    localparam logic [1:0] EDGE_SECOND = 2'd1;
    localparam logic [1:0] EDGE_THIRD  = 2'd2;
    localparam logic [1:0] EDGE_FOURTH = 2'd3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_point;

    typedef struct packed {
        t_point                     cur;
        t_point                     dst;
        logic [DELTA_BITS-1:0]      dx;
        logic [DELTA_BITS-1:0]      dy;
        logic                       sx_neg;
        logic                       sy_neg;
        logic signed [ERR_BITS-1:0] err;
    } t_edge;

    function automatic logic is_last_edge(input t_cmd kind, input logic [1:0] edge_num);
        logic res;
        case (kind)
            CMD_RECT: res = (edge_num == EDGE_FOURTH);
            CMD_TRI:  res = (edge_num == EDGE_THIRD) || (edge_num == EDGE_FOURTH);
            default:  res = 1'b1;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/lpr_edge_setup.sv @@
// Edge setup: picks the two end points of one edge of the primitive and
// derives the Bresenham deltas, step directions and initial error. Uses lpr_pkg.
`default_nettype none

module lpr_edge_setup
    import lpr_pkg::*;
(
    input  wire t_cmd       i_kind,
    input  wire logic [1:0] i_edge_num,
    input  wire t_point     i_v1,
    input  wire t_point     i_v2,
    input  wire t_point     i_v3,
    output t_edge           o_edge
);

    t_point a;
    t_point b;
    logic signed [DELTA_BITS-1:0] ax_w, ay_w, bx_w, by_w;
    logic [DELTA_BITS-1:0] dx, dy;

    always_comb begin
        a = i_v1;
        b = i_v2;
        unique case (i_kind)
            CMD_RECT: begin
                case (i_edge_num)
                    EDGE_FIRST: begin
                        a = i_v1;
                        b = '{x: i_v2.x, y: i_v1.y};
                    end
                    EDGE_SECOND: begin
                        a = '{x: i_v1.x, y: i_v2.y};
                        b = i_v2;
                    end
                    EDGE_THIRD: begin
                        a = i_v1;
                        b = '{x: i_v1.x, y: i_v2.y};
                    end
                    default: begin
                        a = '{x: i_v2.x, y: i_v1.y};
                        b = i_v2;
                    end
                endcase
            end
            CMD_TRI: begin
                case (i_edge_num)
                    EDGE_FIRST: begin
                        a = i_v1;
                        b = i_v2;
                    end
                    EDGE_SECOND: begin
                        a = i_v2;
                        b = i_v3;
                    end
                    default: begin
                        a = i_v3;
                        b = i_v1;
                    end
                endcase
            end
            default: begin
                a = i_v1;
                b = i_v2;
            end
        endcase
    end

    assign ax_w = DELTA_BITS'(a.x);
    assign ay_w = DELTA_BITS'(a.y);
    assign bx_w = DELTA_BITS'(b.x);
    assign by_w = DELTA_BITS'(b.y);

    assign dx = (b.x > a.x) ? DELTA_BITS'(bx_w - ax_w) : DELTA_BITS'(ax_w - bx_w);
    assign dy = (b.y > a.y) ? DELTA_BITS'(by_w - ay_w) : DELTA_BITS'(ay_w - by_w);

    always_comb begin
        o_edge.cur    = a;
        o_edge.dst    = b;
        o_edge.dx     = dx;
        o_edge.dy     = dy;
        o_edge.sx_neg = !(a.x < b.x);
        o_edge.sy_neg = !(a.y < b.y);
        o_edge.err    = $signed({1'b0, dx}) - $signed({1'b0, dy});
    end

endmodule

`default_nettype wire

@@ rtl/lpr_stepper.sv @@
// Bresenham stepper: one step of the current edge and the end-of-edge test.
// Uses lpr_pkg.
`default_nettype none

module lpr_stepper
    import lpr_pkg::*;
(
    input  wire t_edge i_edge,
    output logic       o_at_end,
    output t_edge      o_edge
);

    logic signed [WIDE_BITS-1:0] e2;
    logic signed [WIDE_BITS-1:0] dx_w;
    logic signed [WIDE_BITS-1:0] dy_w;
    logic signed [WIDE_BITS-1:0] err_w;
    logic step_x, step_y;

    assign dx_w   = $signed({2'b00, i_edge.dx});
    assign dy_w   = $signed({2'b00, i_edge.dy});
    assign e2     = WIDE_BITS'(i_edge.err) <<< 1;
    assign step_x = (e2 > -dy_w);
    assign step_y = (e2 < dx_w);
    assign err_w  = WIDE_BITS'(i_edge.err) - (step_x ? dy_w : '0) + (step_y ? dx_w : '0);

    assign o_at_end = (i_edge.cur == i_edge.dst);

    always_comb begin
        o_edge     = i_edge;
        o_edge.err = ERR_BITS'(err_w);
        if (step_x) begin
            o_edge.cur.x = i_edge.sx_neg ? i_edge.cur.x - COORD_BITS'(1)
                                         : i_edge.cur.x + COORD_BITS'(1);
        end
        if (step_y) begin
            o_edge.cur.y = i_edge.sy_neg ? i_edge.cur.y - COORD_BITS'(1)
                                         : i_edge.cur.y + COORD_BITS'(1);
        end
    end

endmodule

`default_nettype wire

@@ rtl/line_polygon_rasterizer_unit.sv @@
// Outline rasterizer for lines, rectangles and triangles (Bresenham).
// Uses lpr_pkg, lpr_edge_setup and lpr_stepper.
//
// Input channel (s_axis): tuser carries the command, tdata the three vertices.
// A start command (line, rectangle, triangle) loads the primitive and returns
// no word; a start while drawing drops the current primitive. Each step
// command returns one pixel word on the output channel (m_axis); tlast marks
// the final pixel of the primitive. A step while idle returns nothing.
// Rectangles draw top, bottom, left, right (corners repeat); triangles draw
// 1-2, 2-3, 3-1.
// A step word's pixel is loaded into the result register by the edge that
// accepts the word. One word is accepted per cycle while the receiver takes
// words; the Bresenham step and the next-edge setup are both evaluated in the
// accepting cycle, so moving to a new edge does not hold the input.
// Reset (synchronous, active low) makes the block idle with no word pending.
// While the receiver stalls, the result register holds its word and the
// input side stalls too; it accepts again in the cycle the word is taken.
`default_nettype none

module line_polygon_rasterizer_unit
    import lpr_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // s_axis
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata from bit 0: first_x, first_y, second_x, second_y, third_x, third_y, zero pad
    input  wire logic [S_TDATA_BITS-1:0] s_axis_tdata,
    // tuser: cmd
    input  wire logic [1:0]              s_axis_tuser,
    // m_axis
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // tdata from bit 0: pixel_x, pixel_y, zero pad
    output logic [M_TDATA_BITS-1:0]      m_axis_tdata,
    output logic                         m_axis_tlast
);

    t_cmd       in_cmd;
    t_point     in_v1, in_v2, in_v3;
    logic       acc;
    logic       is_start;
    logic       emit;

    logic       r_busy;
    t_cmd       r_kind;
    logic [1:0] r_edge_num;
    t_point     r_v1, r_v2, r_v3;
    t_edge      r_edge;

    logic       r_out_valid;
    t_point     r_out_pix;
    logic       r_out_last;

    logic       n_busy;
    t_cmd       n_kind;
    logic [1:0] n_edge_num;
    t_edge      n_edge;

    t_cmd       setup_kind;
    logic [1:0] setup_edge_num;
    t_point     setup_v1, setup_v2, setup_v3;
    t_edge      setup_edge;
    t_edge      stepped_edge;
    logic       at_end;
    logic       final_edge;

    assign in_cmd   = t_cmd'(s_axis_tuser);
    assign in_v1.x  = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
    assign in_v1.y  = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
    assign in_v2.x  = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
    assign in_v2.y  = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
    assign in_v3.x  = s_axis_tdata[4*COORD_BITS +: COORD_BITS];
    assign in_v3.y  = s_axis_tdata[5*COORD_BITS +: COORD_BITS];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign acc      = s_axis_tvalid && s_axis_tready;
    assign is_start = (in_cmd != CMD_STEP);
    assign emit     = acc && !is_start && r_busy;

    // One setup unit serves both the start of a primitive and the hop to its next edge
    assign setup_kind     = is_start ? in_cmd : r_kind;
    assign setup_edge_num = is_start ? EDGE_FIRST : r_edge_num + 2'd1;
    assign setup_v1       = is_start ? in_v1 : r_v1;
    assign setup_v2       = is_start ? in_v2 : r_v2;
    assign setup_v3       = is_start ? in_v3 : r_v3;

    lpr_edge_setup u_setup (
        .i_kind     (setup_kind),
        .i_edge_num (setup_edge_num),
        .i_v1       (setup_v1),
        .i_v2       (setup_v2),
        .i_v3       (setup_v3),
        .o_edge     (setup_edge)
    );

    lpr_stepper u_stepper (
        .i_edge   (r_edge),
        .o_at_end (at_end),
        .o_edge   (stepped_edge)
    );

    assign final_edge = is_last_edge(r_kind, r_edge_num);

    always_comb begin
        n_busy     = r_busy;
        n_kind     = r_kind;
        n_edge_num = r_edge_num;
        n_edge     = r_edge;
        if (acc && is_start) begin
            n_busy     = 1'b1;
            n_kind     = in_cmd;
            n_edge_num = EDGE_FIRST;
            n_edge     = setup_edge;
        end else if (emit) begin
            if (at_end) begin
                if (final_edge) begin
                    n_busy = 1'b0;
                end else begin
                    n_edge_num = setup_edge_num;
                    n_edge     = setup_edge;
                end
            end else begin
                n_edge = stepped_edge;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_kind      <= CMD_LINE;
            r_edge_num  <= EDGE_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_kind     <= n_kind;
            r_edge_num <= n_edge_num;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: vertices, edge walker and result word
    always_ff @(posedge i_clk) begin
        r_edge <= n_edge;
        if (acc && is_start) begin
            r_v1 <= in_v1;
            r_v2 <= in_v2;
            r_v3 <= in_v3;
        end
        if (emit) begin
            r_out_pix  <= r_edge.cur;
            r_out_last <= at_end && final_edge;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_BITS'({r_out_pix.y, r_out_pix.x});
    assign m_axis_tlast  = r_out_last;

    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && is_start) |=> (r_busy && r_edge_num == EDGE_FIRST && !r_out_valid
                               || r_busy && r_edge_num == EDGE_FIRST && $past(r_out_valid)))
        else $error("start did not load a fresh primitive");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_out_valid && (r_out_last == !r_busy)))
        else $error("last pixel flag disagrees with busy state");

    a_line_one_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_kind == CMD_LINE) |-> (r_edge_num == EDGE_FIRST))
        else $error("line walked past its only edge");

    a_tri_three_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_kind == CMD_TRI) |-> (r_edge_num != EDGE_FOURTH))
        else $error("triangle reached a fourth edge");

    a_idle_step_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !is_start && !r_busy && (m_axis_tready || !r_out_valid)) |=> !r_out_valid)
        else $error("step while idle produced a word");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking bench for the line/rectangle/triangle outline rasterizer.
// Drives start and step words on s_axis and checks every pixel word against a
// built-in Bresenham predictor. Depends on lpr_pkg and line_polygon_rasterizer_unit.
`timescale 1ns / 1ps

module tb_top;
    import lpr_pkg::*;

    localparam int COORD_MIN      = -(1 << (COORD_BITS - 1));
    localparam int COORD_MAX      = (1 << (COORD_BITS - 1)) - 1;
    localparam int RANDOM_WORDS   = 1650;
    localparam int STALL_LIMIT    = 5000;
    localparam int RUN_TO_END     = 1 << 20;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
    } t_pixel;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // first_x, first_y, second_x, second_y, third_x, third_y, zero pad
    logic [S_TDATA_BITS-1:0] s_axis_tdata;
    // cmd
    logic [1:0]              s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // pixel_x, pixel_y, zero pad
    logic [M_TDATA_BITS-1:0] m_axis_tdata;
    logic                    m_axis_tlast;

    int idle_pct     = 37;
    int useful_words = 0;
    int quiet_cycles = 0;

    line_polygon_rasterizer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    class pixel_scoreboard;
        t_pixel                     expected_pixels[$];
        int                         errors;
        bit                         drawing;
        t_cmd                       kind;
        logic [1:0]                 edge_idx;
        t_point                     corner[3];
        t_point                     cur;
        t_point                     dst;
        logic [DELTA_BITS-1:0]      dx;
        logic [DELTA_BITS-1:0]      dy;
        logic                       x_neg;
        logic                       y_neg;
        logic signed [ERR_BITS-1:0] err;

        function new();
            errors   = 0;
            drawing  = 0;
            kind     = CMD_LINE;
            edge_idx = EDGE_FIRST;
            cur      = '0;
            dst      = '0;
            dx       = '0;
            dy       = '0;
            x_neg    = 1'b0;
            y_neg    = 1'b0;
            err      = '0;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void begin_edge(t_point a, t_point b);
            cur   = a;
            dst   = b;
            dx    = (b.x > a.x) ? DELTA_BITS'(int'(b.x) - int'(a.x))
                                : DELTA_BITS'(int'(a.x) - int'(b.x));
            dy    = (b.y > a.y) ? DELTA_BITS'(int'(b.y) - int'(a.y))
                                : DELTA_BITS'(int'(a.y) - int'(b.y));
            x_neg = !(a.x < b.x);
            y_neg = !(a.y < b.y);
            err   = ERR_BITS'(int'(dx) - int'(dy));
        endfunction

        function void load_current_edge();
            t_point a;
            t_point b;
            a = corner[0];
            b = corner[1];
            if (kind == CMD_RECT) begin
                // corner[0] and corner[1] are opposite corners
                case (edge_idx)
                    EDGE_FIRST: begin
                        b.y = corner[0].y;
                    end
                    EDGE_SECOND: begin
                        a.y = corner[1].y;
                    end
                    EDGE_THIRD: begin
                        b.x = corner[0].x;
                    end
                    default: begin
                        a.x = corner[1].x;
                    end
                endcase
            end else if (kind == CMD_TRI) begin
                case (edge_idx)
                    EDGE_FIRST: begin
                        a = corner[0];
                        b = corner[1];
                    end
                    EDGE_SECOND: begin
                        a = corner[1];
                        b = corner[2];
                    end
                    default: begin
                        a = corner[2];
                        b = corner[0];
                    end
                endcase
            end
            begin_edge(a, b);
        endfunction

        // Called for every accepted input word
        function void note_word(t_cmd cmd, t_point v1, t_point v2, t_point v3);
            t_pixel px;
            int     e2;
            int     edges;
            if (cmd != CMD_STEP) begin
                corner[0] = v1;
                corner[1] = v2;
                corner[2] = v3;
                kind      = cmd;
                edge_idx  = EDGE_FIRST;
                drawing   = 1;
                load_current_edge();
                return;
            end
            if (!drawing)
                return;
            px.x    = cur.x;
            px.y    = cur.y;
            px.last = 1'b0;
            if (cur == dst) begin
                edges = (kind == CMD_RECT) ? 4 : (kind == CMD_TRI) ? 3 : 1;
                if (int'(edge_idx) + 1 >= edges) begin
                    drawing = 0;
                    px.last = 1'b1;
                end else begin
                    edge_idx = edge_idx + 2'd1;
                    load_current_edge();
                end
            end else begin
                e2 = 2 * int'(err);
                if (e2 > -int'(dy)) begin
                    err   = ERR_BITS'(int'(err) - int'(dy));
                    cur.x = COORD_BITS'(int'(cur.x) + (x_neg ? -1 : 1));
                end
                if (e2 < int'(dx)) begin
                    err   = ERR_BITS'(int'(err) + int'(dx));
                    cur.y = COORD_BITS'(int'(cur.y) + (y_neg ? -1 : 1));
                end
            end
            expected_pixels.push_back(px);
        endfunction

        function void check_pixel(logic [M_TDATA_BITS-1:0] data, logic last);
            t_pixel                       want;
            logic signed [COORD_BITS-1:0] got_x;
            logic signed [COORD_BITS-1:0] got_y;
            got_x = data[COORD_BITS-1:0];
            got_y = data[2*COORD_BITS-1:COORD_BITS];
            if (expected_pixels.size() == 0) begin
                $error("pixel word with none expected: x %0d y %0d last %0b",
                       got_x, got_y, last);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got_x !== want.x) begin
                $error("pixel_x: expected %0d, got %0d", want.x, got_x);
                errors++;
            end
            if (got_y !== want.y) begin
                $error("pixel_y: expected %0d, got %0d", want.y, got_y);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_pixel: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    pixel_scoreboard sb = new();

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_point make_point(int x, int y);
        t_point p;
        p.x = COORD_BITS'(x);
        p.y = COORD_BITS'(y);
        return p;
    endfunction

    function automatic int clamp_coord(int v);
        return (v < COORD_MIN) ? COORD_MIN : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    function automatic t_point any_point();
        return make_point(int'($urandom), int'($urandom));
    endfunction

    function automatic t_point near_point(t_point c, int spread);
        return make_point(
            clamp_coord(int'(c.x) + int'($urandom_range(2 * spread)) - spread),
            clamp_coord(int'(c.y) + int'($urandom_range(2 * spread)) - spread));
    endfunction

    // Entered and left at a falling edge; tvalid stays high into the next word
    task automatic send_word(input t_cmd cmd, input t_point v1, input t_point v2,
                             input t_point v3);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = '0;
        s_axis_tdata[0*COORD_BITS +: COORD_BITS] = v1.x;
        s_axis_tdata[1*COORD_BITS +: COORD_BITS] = v1.y;
        s_axis_tdata[2*COORD_BITS +: COORD_BITS] = v2.x;
        s_axis_tdata[3*COORD_BITS +: COORD_BITS] = v2.y;
        s_axis_tdata[4*COORD_BITS +: COORD_BITS] = v3.x;
        s_axis_tdata[5*COORD_BITS +: COORD_BITS] = v3.y;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        sb.note_word(cmd, v1, v2, v3);
        @(negedge i_clk);
    endtask

    task automatic send_step();
        send_word(CMD_STEP, any_point(), any_point(), any_point());
    endtask

    task automatic wait_for_pixels();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    // Start a primitive and step it until done or until the step budget runs out
    task automatic draw_shape(input t_cmd kind, input t_point v1, input t_point v2,
                              input t_point v3, input int max_steps);
        int n;
        n = 0;
        send_word(kind, v1, v2, v3);
        useful_words++;
        while (sb.drawing && n < max_steps) begin
            send_step();
            useful_words++;
            n++;
        end
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready = ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel(m_axis_tdata, m_axis_tlast);
    end

    // Watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        t_cmd   kind;
        t_point centre;
        int     spread;
        int     budget;
        int     roll;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_STEP;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: idle steps, single-pixel line, abandoned full-range line,
        // corner-of-canvas rectangle and triangle
        send_step();
        draw_shape(CMD_LINE, make_point(5, -7), make_point(5, -7),
                   make_point(COORD_MIN, COORD_MAX), RUN_TO_END);
        send_step();
        draw_shape(CMD_LINE, make_point(COORD_MIN, COORD_MAX),
                   make_point(COORD_MAX, COORD_MIN), make_point(0, 0), 3);
        draw_shape(CMD_RECT, make_point(COORD_MAX, COORD_MIN),
                   make_point(COORD_MAX - 1, COORD_MIN + 1),
                   make_point(COORD_MAX, COORD_MAX), RUN_TO_END);
        draw_shape(CMD_TRI, make_point(COORD_MIN, COORD_MIN),
                   make_point(COORD_MIN + 1, COORD_MIN + 1),
                   make_point(COORD_MIN, COORD_MIN + 1), RUN_TO_END);
        wait_for_pixels();

        useful_words = 0;
        while (useful_words < RANDOM_WORDS) begin
            idle_pct = (useful_words >= 700 && useful_words < 1000) ? 0 : 37;
            kind     = t_cmd'($urandom_range(2));
            roll     = $urandom_range(99);
            if (roll < 5) begin
                // full-range vertices, usually cut short by the next start
                draw_shape(kind, any_point(), any_point(), any_point(),
                           $urandom_range(40));
            end else begin
                roll   = $urandom_range(9);
                spread = (roll == 0) ? 0 : (roll < 4) ? 2 : (roll < 9) ? 6 : 12;
                centre = any_point();
                budget = ($urandom_range(9) == 0) ? $urandom_range(20) : RUN_TO_END;
                draw_shape(kind, near_point(centre, spread), near_point(centre, spread),
                           near_point(centre, spread), budget);
            end
            if (!sb.drawing && $urandom_range(9) == 0)
                repeat ($urandom_range(2, 1)) send_step();
            if ($urandom_range(49) == 0)
                wait_for_pixels();
        end

        wait_for_pixels();
        repeat (16) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
